/* src/rsl_pkg.sv */
// Shared types and codes for the request slot table.
package rsl_pkg;

  // Operation selector carried on the input tuser.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  localparam int KEY_W  = 16;
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 3;

  // One stored table entry: requester key and its network address.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] address;
  } entry_t;

endpackage

/* src/rsl_entry_ram.sv */
// Entry storage RAM: one write port, one read port with registered read data.
module rsl_entry_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  rsl_pkg::entry_t       wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output rsl_pkg::entry_t       rd_data
);

  rsl_pkg::entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/request_slot_table_top.sv */
// Top level of the request slot table: sequencer, valid bits and result register.
//
// The table keeps TABLE_ENTRIES slots, each with a valid bit, a 16-bit requester
// key and a 32-bit address. Operations arrive on the s_ channel, one transfer per
// operation, with the opcode on s_tuser. Every operation returns exactly one
// result transfer on the m_ channel, with the status on m_tuser.
// Clear and remove need no scan. Insert walks the valid bits one slot per cycle
// to find the lowest free slot. Lookup streams the entry RAM one address per
// cycle behind its registered read data and compares each returned entry. Every
// result then passes through the S_EMIT state into the output register. A new
// operation is accepted only once the previous one has its result loaded, and it
// may be accepted while that result still waits in the output register.
// If the receiver stalls, the finished result of the next operation waits in the
// sequencer until the output register is free, and no further input is taken.
// Reset (rst, synchronous, active high) empties the table at once by clearing
// the valid bits; stored keys and addresses are not cleared.
module request_slot_table_top #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // key[15:0], req_address[47:16], slot_index[50:48], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // hit_slot[2:0], hit_address[34:3], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_LOOKUP,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [TABLE_ENTRIES-1:0]       valid;
  logic [IW-1:0]                  ptr;
  logic [IW-1:0]                  cmp_idx;
  logic                           cmp_pending;
  logic [rsl_pkg::KEY_W-1:0]      key_r;
  logic [rsl_pkg::ADDR_W-1:0]     addr_r;
  rsl_pkg::status_t               res_status;
  logic [rsl_pkg::SLOT_W-1:0]     res_slot;
  logic [rsl_pkg::ADDR_W-1:0]     res_addr;

  logic                           wr_en;
  rsl_pkg::entry_t                wr_data;
  rsl_pkg::entry_t                rd_data;
  logic                           in_xfer;
  rsl_pkg::op_t                   in_op;
  logic [rsl_pkg::SLOT_W-1:0]     in_slot;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign in_op    = rsl_pkg::op_t'(s_tuser);
  assign in_slot  = s_tdata[50:48];

  // Insert writes the entry in the cycle it finds the free slot.
  assign wr_en        = (state == S_INSERT) && !valid[ptr];
  assign wr_data.key     = key_r;
  assign wr_data.address = addr_r;

  // Entry storage; the scan reads at the slot pointer. Inserts and lookups never
  // overlap, so reads and writes of one entry do not collide.
  rsl_entry_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (wr_data),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  // Sequencer, valid bits and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      ptr         <= '0;
      cmp_pending <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // The output register empties on a completed transfer unless a new result loads.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            key_r       <= s_tdata[15:0];
            addr_r      <= s_tdata[47:16];
            ptr         <= '0;
            cmp_pending <= 1'b0;
            res_status  <= rsl_pkg::ST_OK;
            res_slot    <= '0;
            res_addr    <= '0;
            unique case (in_op)
              rsl_pkg::OP_CLEAR: begin
                valid <= '0;
                state <= S_EMIT;
              end
              rsl_pkg::OP_INSERT: begin
                state <= S_INSERT;
              end
              rsl_pkg::OP_LOOKUP: begin
                state <= S_LOOKUP;
              end
              rsl_pkg::OP_REMOVE: begin
                // A slot number beyond the table matches no entry and is ignored.
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if ({29'd0, in_slot} == 32'(i)) begin
                    valid[i] <= 1'b0;
                  end
                end
                state <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end

        S_INSERT: begin
          // Walk the valid bits from slot 0 up to the first free one.
          if (!valid[ptr]) begin
            valid[ptr] <= 1'b1;
            res_slot   <= rsl_pkg::SLOT_W'(ptr);
            state      <= S_EMIT;
          end else if (ptr == LAST) begin
            res_status <= rsl_pkg::ST_FULL;
            state      <= S_EMIT;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end

        S_LOOKUP: begin
          // Issue one read per cycle; compare the entry that returns.
          cmp_pending <= 1'b1;
          cmp_idx     <= ptr;
          if (ptr != LAST) begin
            ptr <= ptr + 1'b1;
          end
          if (cmp_pending) begin
            if (valid[cmp_idx] && (rd_data.key == key_r)) begin
              res_slot <= rsl_pkg::SLOT_W'(cmp_idx);
              res_addr <= rd_data.address;
              state    <= S_EMIT;
            end else if (cmp_idx == LAST) begin
              res_status <= rsl_pkg::ST_NOT_FOUND;
              state      <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          // Load the result once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {5'd0, res_addr, res_slot};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
